@@ rtl/core/cmdarb_pkg.sv @@
`timescale 1ns / 1ps

package cmdarb_pkg;

   // field widths
   localparam int unsigned SPEED_W  = 16;
   localparam int unsigned GAIN_W   = 15;
   localparam int unsigned TICK_W   = 8;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned CSR_W    = 15;
   localparam int unsigned NUM_SRC  = 3;

   // item operation codes
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_JOY  = 2'd1,
      OP_MOV  = 2'd2,
      OP_AUX  = 2'd3
   } op_type;

   // source select codes
   localparam logic [1:0] SRC_JOY = 2'd0;
   localparam logic [1:0] SRC_MOV = 2'd1;
   localparam logic [1:0] SRC_AUX = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_HOLD_TICKS    = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd1;
   localparam logic [1:0] CSR_JOY_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_VALUE_LIMIT   = 2'd3;

   // register reset values
   localparam logic [TICK_W-1:0] HOLD_TICKS_RESET    = 8'd100;
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RESET = 8'd10;
   localparam logic [GAIN_W-1:0] JOY_THRESHOLD_RESET = 15'd2560;
   localparam logic [GAIN_W-1:0] VALUE_LIMIT_RESET   = 15'd25600;

   localparam logic [TICK_W-1:0]  AGE_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      op_type                    op;
      logic signed [SPEED_W-1:0] direction;
      logic signed [SPEED_W-1:0] linear;
      logic signed [SPEED_W-1:0] angular;
      logic signed [SPEED_W-1:0] gain;
   } item_type;

   typedef struct packed {
      logic [TICK_W-1:0] hold_ticks;
      logic [TICK_W-1:0] timeout_ticks;
      logic [GAIN_W-1:0] joy_gain_threshold;
      logic [GAIN_W-1:0] value_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] linear;
      logic signed [SPEED_W-1:0] angular;
      logic [GAIN_W-1:0]         gain;
   } clamped_type;

   // control from the input stage to the state block
   typedef struct packed {
      logic   apply;
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] direction;
      logic signed [SPEED_W-1:0] linear;
      logic signed [SPEED_W-1:0] angular;
      logic [GAIN_W-1:0]         gain;
      logic [1:0]                source_sel;
      logic [COUNT_W-1:0]        joy_timeouts;
      logic [COUNT_W-1:0]        mov_timeouts;
      logic [COUNT_W-1:0]        aux_timeouts;
   } result_type;

endpackage

@@ rtl/core/cmdarb_req_if.sv @@
`timescale 1ns / 1ps

interface cmdarb_req_if;
   import cmdarb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                op;
   logic signed [SPEED_W-1:0] direction_in;
   logic signed [SPEED_W-1:0] linear_in;
   logic signed [SPEED_W-1:0] angular_in;
   logic signed [SPEED_W-1:0] gain_in;

   modport source (output valid, op, direction_in, linear_in, angular_in, gain_in,
                   input ready);
   modport sink (input valid, op, direction_in, linear_in, angular_in, gain_in,
                 output ready);
endinterface

@@ rtl/core/cmdarb_rsp_if.sv @@
`timescale 1ns / 1ps

interface cmdarb_rsp_if;
   import cmdarb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] direction_out;
   logic signed [SPEED_W-1:0] linear_out;
   logic signed [SPEED_W-1:0] angular_out;
   logic [GAIN_W-1:0]         gain_out;
   logic [1:0]                source_sel;
   logic [COUNT_W-1:0]        joy_timeouts;
   logic [COUNT_W-1:0]        mov_timeouts;
   logic [COUNT_W-1:0]        aux_timeouts;

   modport source (output valid, direction_out, linear_out, angular_out, gain_out,
                   source_sel, joy_timeouts, mov_timeouts, aux_timeouts,
                   input ready);
   modport sink (input valid, direction_out, linear_out, angular_out, gain_out,
                 source_sel, joy_timeouts, mov_timeouts, aux_timeouts,
                 output ready);
endinterface

@@ rtl/core/command_source_arbiter_watchdog.sv @@
`timescale 1ns / 1ps

// channel  | direction | payload
// ---------+-----------+------------------------------------------------------
// req_ch   | in        | op, direction_in, linear_in, angular_in, gain_in
// rsp_ch   | out       | direction_out, linear_out, angular_out, gain_out,
//          |           | source_sel, joy_timeouts, mov_timeouts, aux_timeouts
// csr_*    | in        | csr_we, csr_index, csr_wdata (write only)
//
// one item per cycle while no tick is stalled; each item is registered in the input
// register, and a tick's result is registered in the output register as the tick leaves it
// messages update the source state and produce no result
// synchronous active-high reset clears all source state and loads register defaults
// a tick waits in the input register only while the output register holds an
// untaken result; messages pass through regardless

module command_source_arbiter_watchdog (
   input  logic                        clock,
   input  logic                        reset,
   cmdarb_req_if.sink                  req_ch,
   cmdarb_rsp_if.source                rsp_ch,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [cmdarb_pkg::CSR_W-1:0] csr_wdata
);
   import cmdarb_pkg::*;

   cfg_type     cfg_ff;
   item_type    in_ff;
   logic        in_valid_ff;
   result_type  out_ff;
   logic        out_valid_ff;
   logic        take;
   logic        advance;
   logic        out_free;
   logic        tick_done;
   ctrl_type    ctrl;
   clamped_type clamped;
   result_type  result;

   // handshake
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && (in_ff.op != OP_TICK || out_free);
   assign tick_done    = advance && in_ff.op == OP_TICK;
   assign req_ch.ready = !in_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;
   assign ctrl.apply   = advance;
   assign ctrl.op      = in_ff.op;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks         <= HOLD_TICKS_RESET;
         cfg_ff.timeout_ticks      <= TIMEOUT_TICKS_RESET;
         cfg_ff.joy_gain_threshold <= JOY_THRESHOLD_RESET;
         cfg_ff.value_limit        <= VALUE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HOLD_TICKS:    cfg_ff.hold_ticks         <= csr_wdata[TICK_W-1:0];
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks      <= csr_wdata[TICK_W-1:0];
            CSR_JOY_THRESHOLD: cfg_ff.joy_gain_threshold <= csr_wdata[GAIN_W-1:0];
            CSR_VALUE_LIMIT:   cfg_ff.value_limit        <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff.op        <= op_type'(req_ch.op);
         in_ff.direction <= req_ch.direction_in;
         in_ff.linear    <= req_ch.linear_in;
         in_ff.angular   <= req_ch.angular_in;
         in_ff.gain      <= req_ch.gain_in;
      end
   end

   // clamp and source state
   cmdarb_clamp u_clamp (
      .item        (in_ff),
      .value_limit (cfg_ff.value_limit),
      .clamped     (clamped)
   );

   cmdarb_state u_state (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .direction (in_ff.direction),
      .clamped   (clamped),
      .cfg       (cfg_ff),
      .result    (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (tick_done) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_done) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.direction_out = out_ff.direction;
   assign rsp_ch.linear_out    = out_ff.linear;
   assign rsp_ch.angular_out   = out_ff.angular;
   assign rsp_ch.gain_out      = out_ff.gain;
   assign rsp_ch.source_sel    = out_ff.source_sel;
   assign rsp_ch.joy_timeouts  = out_ff.joy_timeouts;
   assign rsp_ch.mov_timeouts  = out_ff.mov_timeouts;
   assign rsp_ch.aux_timeouts  = out_ff.aux_timeouts;

`ifndef NO_ASSERTIONS
   // a result only ever appears after a tick left the input register
   a_result_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff && in_ff.op == OP_TICK))
      else $error("result appeared without a tick");

   // the selected source is one of the three sources
   a_source_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.source_sel <= SRC_AUX)
      else $error("source select out of range");

   // clamped speeds never reach the most negative code
   a_speed_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.linear != {1'b1, {(SPEED_W-1){1'b0}}} &&
                        out_ff.angular != {1'b1, {(SPEED_W-1){1'b0}}}))
      else $error("speed outside clamp range");

   // an item held in the input register is a tick blocked by a full output
   a_hold_reason: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> (in_ff.op == OP_TICK && out_valid_ff && !rsp_ch.ready))
      else $error("input stalled without cause");
`endif

endmodule

@@ rtl/core/cmdarb_clamp.sv @@
`timescale 1ns / 1ps

module cmdarb_clamp (
   input  cmdarb_pkg::item_type    item,
   input  logic [cmdarb_pkg::GAIN_W-1:0] value_limit,
   output cmdarb_pkg::clamped_type clamped
);
   import cmdarb_pkg::*;

   logic signed [SPEED_W-1:0] lim_pos;
   logic signed [SPEED_W-1:0] lim_neg;

   // symmetric clamp of a speed to plus or minus the limit
   function automatic logic signed [SPEED_W-1:0] clamp_sym(
      input logic signed [SPEED_W-1:0] v,
      input logic signed [SPEED_W-1:0] hi,
      input logic signed [SPEED_W-1:0] lo
   );
      logic signed [SPEED_W-1:0] r;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign lim_pos = signed'({1'b0, value_limit});
   assign lim_neg = -lim_pos;

   // speeds clamp both ways, gain to zero through the limit
   always_comb begin
      clamped.linear  = clamp_sym(item.linear, lim_pos, lim_neg);
      clamped.angular = clamp_sym(item.angular, lim_pos, lim_neg);
      if (item.gain < 0) begin
         clamped.gain = '0;
      end else if (item.gain > lim_pos) begin
         clamped.gain = value_limit;
      end else begin
         clamped.gain = item.gain[GAIN_W-1:0];
      end
   end

endmodule

@@ rtl/core/cmdarb_state.sv @@
`timescale 1ns / 1ps

module cmdarb_state (
   input  logic                            clock,
   input  logic                            reset,
   input  cmdarb_pkg::ctrl_type            ctrl,
   input  logic signed [cmdarb_pkg::SPEED_W-1:0] direction,
   input  cmdarb_pkg::clamped_type         clamped,
   input  cmdarb_pkg::cfg_type             cfg,
   output cmdarb_pkg::result_type          result
);
   import cmdarb_pkg::*;

   logic signed [SPEED_W-1:0] dir_ff     [NUM_SRC];
   logic signed [SPEED_W-1:0] dir_in     [NUM_SRC];
   logic signed [SPEED_W-1:0] lin_ff     [NUM_SRC];
   logic signed [SPEED_W-1:0] lin_in     [NUM_SRC];
   logic signed [SPEED_W-1:0] ang_ff     [NUM_SRC];
   logic signed [SPEED_W-1:0] ang_in     [NUM_SRC];
   logic [GAIN_W-1:0]         gain_ff    [NUM_SRC];
   logic [GAIN_W-1:0]         gain_in    [NUM_SRC];
   logic [TICK_W-1:0]         age_ff     [NUM_SRC];
   logic [TICK_W-1:0]         age_in     [NUM_SRC];
   logic [COUNT_W-1:0]        count_ff   [NUM_SRC];
   logic [COUNT_W-1:0]        count_in   [NUM_SRC];
   logic [TICK_W-1:0]         hold_ff    [2];
   logic [TICK_W-1:0]         hold_in    [2];
   logic [1:0]                sel;
   logic [1:0]                slot;
   logic [TICK_W-1:0]         age_next;

   // priority: joystick, then movement, then auxiliary
   assign sel  = (hold_ff[0] != '0) ? SRC_JOY : ((hold_ff[1] != '0) ? SRC_MOV : SRC_AUX);
   assign slot = 2'(ctrl.op) - 2'd1;

   // message store, watchdog and hold countdown
   always_comb begin
      age_next = '0;
      for (int i = 0; i < NUM_SRC; i++) begin
         dir_in[i]   = dir_ff[i];
         lin_in[i]   = lin_ff[i];
         ang_in[i]   = ang_ff[i];
         gain_in[i]  = gain_ff[i];
         age_in[i]   = age_ff[i];
         count_in[i] = count_ff[i];
      end
      for (int i = 0; i < 2; i++) begin
         hold_in[i] = hold_ff[i];
      end
      if (ctrl.apply) begin
         if (ctrl.op != OP_TICK) begin
            dir_in[slot]  = direction;
            lin_in[slot]  = clamped.linear;
            ang_in[slot]  = clamped.angular;
            gain_in[slot] = clamped.gain;
            age_in[slot]  = '0;
            if (ctrl.op == OP_MOV) begin
               hold_in[1] = cfg.hold_ticks;
            end else if (ctrl.op == OP_JOY && clamped.gain > cfg.joy_gain_threshold) begin
               hold_in[0] = cfg.hold_ticks;
            end
         end else begin
            for (int i = 0; i < NUM_SRC; i++) begin
               age_next  = (age_ff[i] == AGE_MAX) ? AGE_MAX : age_ff[i] + 8'd1;
               age_in[i] = age_next;
               if (age_next > cfg.timeout_ticks) begin
                  dir_in[i]  = '0;
                  lin_in[i]  = '0;
                  ang_in[i]  = '0;
                  gain_in[i] = '0;
                  if (count_ff[i] != COUNT_MAX) begin
                     count_in[i] = count_ff[i] + 16'd1;
                  end
               end
            end
            for (int i = 0; i < 2; i++) begin
               if (hold_ff[i] != '0) begin
                  hold_in[i] = hold_ff[i] - 8'd1;
               end
            end
         end
      end
   end

   // result: values from before the watchdog, counts after it
   always_comb begin
      result.direction    = dir_ff[sel];
      result.linear       = lin_ff[sel];
      result.angular      = ang_ff[sel];
      result.gain         = gain_ff[sel];
      result.source_sel   = sel;
      result.joy_timeouts = count_in[0];
      result.mov_timeouts = count_in[1];
      result.aux_timeouts = count_in[2];
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SRC; i++) begin
            dir_ff[i]   <= '0;
            lin_ff[i]   <= '0;
            ang_ff[i]   <= '0;
            gain_ff[i]  <= '0;
            age_ff[i]   <= '0;
            count_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            hold_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_SRC; i++) begin
            dir_ff[i]   <= dir_in[i];
            lin_ff[i]   <= lin_in[i];
            ang_ff[i]   <= ang_in[i];
            gain_ff[i]  <= gain_in[i];
            age_ff[i]   <= age_in[i];
            count_ff[i] <= count_in[i];
         end
         for (int i = 0; i < 2; i++) begin
            hold_ff[i] <= hold_in[i];
         end
      end
   end

endmodule

@@ test/cmdarb_selection_checker.sv @@
`timescale 1ns / 1ps

module cmdarb_selection_checker
   import cmdarb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   cmdarb_req_if            req_mon,
   cmdarb_rsp_if            rsp_mon,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending
);

   // shadow copy of the registers
   logic [TICK_W-1:0] hold_len;
   logic [TICK_W-1:0] stale_after;
   logic [GAIN_W-1:0] joy_threshold;
   logic [GAIN_W-1:0] limit;

   // shadow copy of the per-source state
   logic signed [SPEED_W-1:0] src_direction [NUM_SRC];
   logic signed [SPEED_W-1:0] src_linear [NUM_SRC];
   logic signed [SPEED_W-1:0] src_angular [NUM_SRC];
   logic [GAIN_W-1:0]         src_gain [NUM_SRC];
   logic [TICK_W-1:0]         src_age [NUM_SRC];
   logic [TICK_W-1:0]         hold_left [2];
   logic [COUNT_W-1:0]        stale_count [NUM_SRC];

   result_type expected_selections[$];
   result_type want;

   function automatic logic signed [SPEED_W-1:0] clamp_speed(logic signed [SPEED_W-1:0] v,
                                                             logic [GAIN_W-1:0] lim);
      int vi;
      int li;
      vi = int'(v);
      li = int'(lim);
      if (vi > li) vi = li;
      else if (vi < -li) vi = -li;
      return SPEED_W'(vi);
   endfunction

   function automatic logic [GAIN_W-1:0] clamp_gain(logic signed [SPEED_W-1:0] g,
                                                    logic [GAIN_W-1:0] lim);
      int gi;
      int li;
      gi = int'(g);
      li = int'(lim);
      if (gi > li) gi = li;
      if (gi < 0) gi = 0;
      return GAIN_W'(gi);
   endfunction

   // a message overwrites one source and may grant it priority
   task automatic store_message(logic [1:0] s, logic signed [SPEED_W-1:0] direction,
                                logic signed [SPEED_W-1:0] linear,
                                logic signed [SPEED_W-1:0] angular,
                                logic signed [SPEED_W-1:0] gain);
      src_direction[s] = direction;
      src_linear[s]    = clamp_speed(linear, limit);
      src_angular[s]   = clamp_speed(angular, limit);
      src_gain[s]      = clamp_gain(gain, limit);
      src_age[s]       = '0;
      if (s == SRC_MOV)
         hold_left[1] = hold_len;
      else if (s == SRC_JOY && src_gain[SRC_JOY] > joy_threshold)
         hold_left[0] = hold_len;
   endtask

   // selection from the old state, then watchdog and hold countdown
   task automatic predict_tick(output result_type r);
      logic [1:0] sel;
      sel = (hold_left[0] != '0) ? SRC_JOY :
            (hold_left[1] != '0) ? SRC_MOV : SRC_AUX;
      r.direction  = src_direction[sel];
      r.linear     = src_linear[sel];
      r.angular    = src_angular[sel];
      r.gain       = src_gain[sel];
      r.source_sel = sel;
      for (int i = 0; i < NUM_SRC; i++) begin
         if (src_age[i] != AGE_MAX) src_age[i]++;
         if (src_age[i] > stale_after) begin
            src_direction[i] = '0;
            src_linear[i]    = '0;
            src_angular[i]   = '0;
            src_gain[i]      = '0;
            if (stale_count[i] != COUNT_MAX) stale_count[i]++;
         end
      end
      for (int i = 0; i < 2; i++)
         if (hold_left[i] != '0) hold_left[i]--;
      r.joy_timeouts = stale_count[SRC_JOY];
      r.mov_timeouts = stale_count[SRC_MOV];
      r.aux_timeouts = stale_count[SRC_AUX];
   endtask

   task automatic compare_field(string name, int expv, int actv);
      if (expv != actv) begin
         $error("%s: expected %0d, actual %0d", name, expv, actv);
         fail_count++;
      end
   endtask

   // watch the channels and the register port
   always @(posedge clock) begin
      if (reset) begin
         hold_len      = HOLD_TICKS_RESET;
         stale_after   = TIMEOUT_TICKS_RESET;
         joy_threshold = JOY_THRESHOLD_RESET;
         limit         = VALUE_LIMIT_RESET;
         for (int i = 0; i < NUM_SRC; i++) begin
            src_direction[i] = '0;
            src_linear[i]    = '0;
            src_angular[i]   = '0;
            src_gain[i]      = '0;
            src_age[i]       = '0;
            stale_count[i]   = '0;
         end
         hold_left[0] = '0;
         hold_left[1] = '0;
         expected_selections.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HOLD_TICKS:    hold_len      = csr_wdata[TICK_W-1:0];
               CSR_TIMEOUT_TICKS: stale_after   = csr_wdata[TICK_W-1:0];
               CSR_JOY_THRESHOLD: joy_threshold = csr_wdata[GAIN_W-1:0];
               CSR_VALUE_LIMIT:   limit         = csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end

         // compare a taken result with the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_selections.size() == 0) begin
               $error("result with nothing expected: source_sel %0d", rsp_mon.source_sel);
               fail_count++;
            end else begin
               want = expected_selections.pop_front();
               compare_field("direction_out", int'(want.direction),
                             int'(rsp_mon.direction_out));
               compare_field("linear_out", int'(want.linear), int'(rsp_mon.linear_out));
               compare_field("angular_out", int'(want.angular), int'(rsp_mon.angular_out));
               compare_field("gain_out", int'(want.gain), int'(rsp_mon.gain_out));
               compare_field("source_sel", int'(want.source_sel), int'(rsp_mon.source_sel));
               compare_field("joy_timeouts", int'(want.joy_timeouts),
                             int'(rsp_mon.joy_timeouts));
               compare_field("mov_timeouts", int'(want.mov_timeouts),
                             int'(rsp_mon.mov_timeouts));
               compare_field("aux_timeouts", int'(want.aux_timeouts),
                             int'(rsp_mon.aux_timeouts));
            end
         end

         // update the prediction with an accepted item
         if (req_mon.valid && req_mon.ready) begin
            case (op_type'(req_mon.op))
               OP_TICK: begin
                  predict_tick(want);
                  expected_selections.push_back(want);
               end
               OP_JOY: store_message(SRC_JOY, req_mon.direction_in, req_mon.linear_in,
                                     req_mon.angular_in, req_mon.gain_in);
               OP_MOV: store_message(SRC_MOV, req_mon.direction_in, req_mon.linear_in,
                                     req_mon.angular_in, req_mon.gain_in);
               default: store_message(SRC_AUX, req_mon.direction_in, req_mon.linear_in,
                                      req_mon.angular_in, req_mon.gain_in);
            endcase
         end
      end
      pending = expected_selections.size();
   end

endmodule

@@ test/command_source_arbiter_watchdog_test.sv @@
`timescale 1ns / 1ps

module command_source_arbiter_watchdog_test;
   import cmdarb_pkg::*;

   localparam int CYCLE_LIMIT = 40000;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [CSR_W-1:0] csr_wdata;

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int pending;
   int cycles;
   int cur_limit;
   int cur_threshold;

   cmdarb_req_if req_ch ();
   cmdarb_rsp_if rsp_ch ();

   command_source_arbiter_watchdog i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cmdarb_selection_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("command_source_arbiter_watchdog verification failed");
         $finish;
      end
   end

   // result receiver with random stalls
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_item(op_type op, int direction, int linear, int angular, int gain);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.op           = op;
      req_ch.direction_in = SPEED_W'(direction);
      req_ch.linear_in    = SPEED_W'(linear);
      req_ch.angular_in   = SPEED_W'(angular);
      req_ch.gain_in      = SPEED_W'(gain);
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, int value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = CSR_W'(value);
      case (index)
         CSR_JOY_THRESHOLD: cur_threshold = value;
         CSR_VALUE_LIMIT:   cur_limit = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // let every expected result arrive and in-flight messages settle
   task automatic drain();
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // any 16-bit signed value, uniformly
   function automatic int pick_word();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int pick_speed(int lim);
      case ($urandom_range(0, 7))
         0:       return -32768;
         1:       return 32767;
         2:       return lim;
         3:       return -lim;
         4:       return lim + 1;
         5:       return -lim - 1;
         6:       return int'($urandom_range(0, 32)) - 16;
         default: return pick_word();
      endcase
   endfunction

   // gains cluster around the limit and the joystick threshold
   function automatic int pick_gain(int lim, int thr);
      case ($urandom_range(0, 7))
         0:       return thr;
         1:       return thr + 1;
         2:       return thr - 1;
         3:       return int'($urandom_range(0, thr));
         4:       return thr + int'($urandom_range(0, 4000));
         default: return pick_speed(lim);
      endcase
   endfunction

   task automatic random_item();
      op_type op;
      int     r;
      r = $urandom_range(0, 99);
      op = (r < 40) ? OP_TICK : (r < 65) ? OP_JOY : (r < 80) ? OP_MOV : OP_AUX;
      send_item(op, ($urandom_range(0, 3) == 0) ? pick_speed(cur_limit) : pick_word(),
                pick_speed(cur_limit), pick_speed(cur_limit),
                pick_gain(cur_limit, cur_threshold));
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_HOLD_TICKS;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.op           = OP_TICK;
      req_ch.direction_in = '0;
      req_ch.linear_in    = '0;
      req_ch.angular_in   = '0;
      req_ch.gain_in      = '0;
      cur_limit           = int'(VALUE_LIMIT_RESET);
      cur_threshold       = int'(JOY_THRESHOLD_RESET);
      send_idle_pct       = 26;
      recv_idle_pct       = 46;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // defaults: empty state, clamping of extremes, joystick priority over movement
      send_item(OP_TICK, 0, 0, 0, 0);
      send_item(OP_JOY, -32768, 32767, -32768, 32767);
      send_item(OP_TICK, 0, 0, 0, 0);
      send_item(OP_MOV, 32767, -32768, 32767, -32768);
      send_item(OP_TICK, 0, 0, 0, 0);
      send_item(OP_AUX, 1, -1, 1, -1);
      send_item(OP_JOY, 100, 200, -200, 2560);
      send_item(OP_TICK, 0, 0, 0, 0);

      // zero limit, zero hold length, zero threshold
      drain();
      write_csr(CSR_VALUE_LIMIT, 0);
      write_csr(CSR_HOLD_TICKS, 0);
      write_csr(CSR_JOY_THRESHOLD, 0);
      send_item(OP_JOY, 5, 1000, -1000, 1000);
      send_item(OP_MOV, -5, -1000, 1000, 25);
      send_item(OP_AUX, 7, 1, -1, 1);
      send_item(OP_TICK, 0, 0, 0, 0);

      // zero timeout: every source goes stale at once
      drain();
      write_csr(CSR_TIMEOUT_TICKS, 0);
      send_item(OP_TICK, 0, 0, 0, 0);
      send_item(OP_TICK, 0, 0, 0, 0);

      // timeout that can never expire, widest limit, threshold edges
      drain();
      write_csr(CSR_TIMEOUT_TICKS, 255);
      write_csr(CSR_VALUE_LIMIT, 32767);
      write_csr(CSR_JOY_THRESHOLD, 25600);
      write_csr(CSR_HOLD_TICKS, 255);
      send_item(OP_JOY, 11, -32768, 32767, 25601);
      send_item(OP_TICK, 0, 0, 0, 0);
      send_item(OP_JOY, -11, 12, -12, 25600);
      send_item(OP_TICK, 0, 0, 0, 0);
      send_item(OP_AUX, 3, 4, 5, 6);
      send_item(OP_TICK, 0, 0, 0, 0);

      // random phases with a fresh setting each
      for (int phase = 0; phase < 3; phase++) begin
         drain();
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 46 : 0;
         recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 26 : 0;
         case (phase)
            0: begin
               write_csr(CSR_HOLD_TICKS, $urandom_range(0, 40));
               write_csr(CSR_TIMEOUT_TICKS, $urandom_range(0, 12));
               write_csr(CSR_JOY_THRESHOLD, $urandom_range(0, 25600));
               write_csr(CSR_VALUE_LIMIT, $urandom_range(0, 32767));
            end
            1: begin
               write_csr(CSR_HOLD_TICKS, $urandom_range(1, 8));
               write_csr(CSR_TIMEOUT_TICKS, $urandom_range(0, 4));
               write_csr(CSR_JOY_THRESHOLD, $urandom_range(0, 3000));
               write_csr(CSR_VALUE_LIMIT, $urandom_range(0, 25600));
            end
            default: begin
               write_csr(CSR_HOLD_TICKS, $urandom_range(0, 255));
               write_csr(CSR_TIMEOUT_TICKS, $urandom_range(0, 30));
               write_csr(CSR_JOY_THRESHOLD, $urandom_range(0, 25600));
               write_csr(CSR_VALUE_LIMIT, 32767);
            end
         endcase
         repeat (160) random_item();
      end

      // long silence: ages saturate and pass the largest timeout that can expire
      drain();
      write_csr(CSR_TIMEOUT_TICKS, 254);
      send_item(OP_JOY, 1, 2, 3, 4);
      send_item(OP_MOV, 5, 6, 7, 8);
      send_item(OP_AUX, 9, 10, 11, 12);
      repeat (260) send_item(OP_TICK, 0, 0, 0, 0);

      drain();
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("command_source_arbiter_watchdog verification clean");
      else
         $display("command_source_arbiter_watchdog verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/cmdarb_pkg.sv
rtl/core/cmdarb_req_if.sv
rtl/core/cmdarb_rsp_if.sv
rtl/core/cmdarb_clamp.sv
rtl/core/cmdarb_state.sv
rtl/core/command_source_arbiter_watchdog.sv
test/cmdarb_selection_checker.sv
test/command_source_arbiter_watchdog_test.sv
